/* src/assert_macros.svh */
// Assertion macros used by the RTL file line_sensor_p_steering.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset
`define LSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define LSPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lsps_pkg.sv */
// Types, constants and the sensor weight table for the line sensor steering block
package lsps_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int THRESH_RESET    = 500;
  localparam int SENSOR_COUNT    = 7;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 8;
  localparam int DIV_STEPS       = 5;

  localparam logic [7:0] BASE_RESET = 8'd85;
  localparam logic [4:0] GAIN_RESET = 5'd8;

  localparam logic [2:0] THRESH_CHANNEL = 3'd7;
  localparam logic [2:0] LAST_SENSOR    = 3'd6;
  localparam logic [2:0] LAST_DIV_STEP  = 3'(DIV_STEPS - 1);
  localparam logic [2:0] ALL_COUNT      = 3'(SENSOR_COUNT);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_MUL,
    S_LEFT,
    S_RIGHT,
    S_EMIT
  } state_t;

  function automatic logic signed [4:0] sensor_weight(input logic [2:0] idx);
    logic signed [4:0] w;
    case (idx)
      3'd0: w = -5'sd9;
      3'd1: w = -5'sd6;
      3'd2: w = -5'sd3;
      3'd3: w = 5'sd0;
      3'd4: w = 5'sd3;
      3'd5: w = 5'sd6;
      3'd6: w = 5'sd9;
      default: w = 5'sd0;
    endcase
    return w;
  endfunction

endpackage

/* src/line_sensor_p_steering.sv */
// Line sensor steering: weighted centroid error and proportional motor drive
// Sample item: the block is ready again on the next cycle.
// Tick with a result: states SCAN, DIV, MUL, LEFT, RIGHT and EMIT, output registered on leaving EMIT;
// tick without a result: back to IDLE after SCAN. One adder serves the 7-step sensor scan, the
// 5-step restoring divide and the two drive sums, one item at a time.
// Synchronous active-low reset: threshold 500, base 85, gain 8, sensor bits and count 0.
`include "assert_macros.svh"

module line_sensor_p_steering import lsps_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [2:0]             in_channel,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_obstacle,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_left_drive,
  output logic [7:0]             out_right_drive,
  output logic signed [4:0]      out_position_error,
  output logic                   out_all_dark_stop
);

  state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] threshold_r;
  logic [6:0]             sensor_bits_r;
  logic [7:0]             base_r;
  logic [4:0]             gain_r;
  logic [2:0]             prev_count_r;
  logic [2:0]             idx_r;
  logic [2:0]             count_r;
  logic signed [5:0]      sum_r;
  logic                   obst_r;
  logic                   stop_r;
  logic                   neg_r;
  logic [2:0]             rem_r;
  logic [4:0]             quo_r;
  logic [8:0]             prod_r;
  logic signed [4:0]      err_r;
  logic [7:0]             left_r;
  logic [7:0]             right_r;

  logic                   out_valid_r;
  logic [7:0]             out_left_r;
  logic [7:0]             out_right_r;
  logic signed [4:0]      out_err_r;
  logic                   out_stop_r;

  logic signed [10:0]     alu_a, alu_b, alu_res;
  logic                   alu_sub;
  logic                   cur_bit;
  logic [2:0]             count_fin;
  logic signed [5:0]      sum_fin;
  logic [5:0]             sum_abs;
  logic [3:0]             shifted;
  logic                   div_ge;
  logic                   in_xfer;
  logic                   out_load;

  function automatic logic [7:0] sat8(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 11'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  assign cur_bit   = sensor_bits_r[idx_r];
  assign count_fin = count_r + {2'b0, cur_bit};
  assign sum_fin   = alu_res[5:0];
  assign sum_abs   = sum_fin[5] ? 6'(-sum_fin) : sum_fin;
  assign shifted   = {rem_r, quo_r[4]};
  assign div_ge    = !alu_res[10];
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign alu_res   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_cmd == CMD_TICK) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == LAST_SENSOR) begin
          state_nxt = (count_fin != 3'd0 && !obst_r) ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        if (idx_r == LAST_DIV_STEP) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_LEFT;
      S_LEFT:  state_nxt = S_RIGHT;
      S_RIGHT: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != S_IDLE);
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    case (state_r)
      S_SCAN: begin
        alu_a = 11'(sum_r);
        alu_b = cur_bit ? 11'(sensor_weight(idx_r)) : 11'sd0;
      end
      S_DIV: begin
        alu_a   = {7'b0, shifted};
        alu_b   = {8'b0, count_r};
        alu_sub = 1'b1;
      end
      S_LEFT: begin
        alu_a   = {3'b0, base_r};
        alu_b   = {2'b0, prod_r};
        alu_sub = neg_r;
      end
      S_RIGHT: begin
        alu_a   = {3'b0, base_r};
        alu_b   = {2'b0, prod_r};
        alu_sub = !neg_r;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      threshold_r   <= SAMPLE_BITS'(THRESH_RESET);
      sensor_bits_r <= '0;
      base_r        <= BASE_RESET;
      gain_r        <= GAIN_RESET;
      prev_count_r  <= '0;
      idx_r         <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      obst_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_SPEED: base_r <= cfg_wdata;
          REG_STEER_GAIN: gain_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end

      if (in_xfer && in_cmd == CMD_SAMPLE) begin
        if (in_channel == THRESH_CHANNEL) begin
          threshold_r <= in_sample;
        end else begin
          sensor_bits_r[in_channel] <= (in_sample <= threshold_r);
        end
      end

      if (in_xfer && in_cmd == CMD_TICK) begin
        obst_r  <= in_obstacle;
        idx_r   <= '0;
        count_r <= '0;
        sum_r   <= '0;
      end

      case (state_r)
        S_SCAN: begin
          count_r <= count_fin;
          sum_r   <= sum_fin;
          if (idx_r == LAST_SENSOR) begin
            prev_count_r <= count_fin;
            idx_r        <= '0;
          end else begin
            idx_r <= idx_r + 3'd1;
          end
        end
        S_DIV: begin
          idx_r <= idx_r + 3'd1;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_SCAN: begin
        if (idx_r == LAST_SENSOR) begin
          stop_r <= (count_fin == ALL_COUNT) && (prev_count_r == ALL_COUNT);
          neg_r  <= sum_fin[5];
          quo_r  <= sum_abs[4:0];
          rem_r  <= '0;
        end
      end
      S_DIV: begin
        rem_r <= div_ge ? alu_res[2:0] : shifted[2:0];
        quo_r <= {quo_r[3:0], div_ge};
      end
      S_MUL: begin
        prod_r <= 9'(gain_r) * 9'(quo_r[3:0]);
        err_r  <= neg_r ? 5'(-signed'(quo_r)) : signed'(quo_r);
      end
      S_LEFT:  left_r  <= sat8(alu_res);
      S_RIGHT: right_r <= sat8(alu_res);
      default: ;
    endcase

    if (out_load) begin
      out_left_r  <= stop_r ? 8'd0 : left_r;
      out_right_r <= stop_r ? 8'd0 : right_r;
      out_err_r   <= err_r;
      out_stop_r  <= stop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_drive     = out_left_r;
  assign out_right_drive    = out_right_r;
  assign out_position_error = out_err_r;
  assign out_all_dark_stop  = out_stop_r;

  `LSPS_ASSERT(a_stop_zero_drive,
    out_valid && out_all_dark_stop |-> out_left_drive == 8'd0 && out_right_drive == 8'd0
      && out_position_error == 5'sd0,
    "stop result with nonzero drive or error")
  `LSPS_ASSERT(a_err_range,
    out_valid |-> out_position_error >= -5'sd9 && out_position_error <= 5'sd9,
    "position error out of range")
  `LSPS_ASSERT(a_rise_from_emit, $rose(out_valid) |-> $past(state_r) == S_EMIT,
    "result appeared outside emit")
  `LSPS_ASSERT(a_busy_stall, state_r != S_IDLE |-> in_stall, "input taken while busy")

endmodule

/* verif/line_sensor_p_steering_tb.sv */
// Testbench for line_sensor_p_steering: directed table, then random items checked by a predictor
module line_sensor_p_steering_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsps_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int SMP_MAX      = (1 << SB) - 1;
  localparam int DIR_ROWS     = 24;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 24;
  localparam int SETTLE_TAIL  = 30;

  typedef struct packed {
    logic          cmd;
    logic [2:0]    channel;
    logic [SB-1:0] sample;
    logic          obstacle;
  } steer_item_t;

  typedef struct packed {
    logic [7:0]        left;
    logic [7:0]        right;
    logic signed [4:0] err;
    logic              stop;
  } drive_t;

  typedef struct packed {
    steer_item_t item;
    logic        typed;
    drive_t      want;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  localparam drive_t NO_DRIVE = '0;
  localparam int LINE_WEIGHT [SENSOR_COUNT] = '{-9, -6, -3, 0, 3, 6, 9};
  localparam logic [7:0] EDGE_BASE [4] = '{8'd255, 8'd0, 8'd255, 8'd0};
  localparam logic [4:0] EDGE_GAIN [4] = '{5'd31, 5'd31, 5'd0, 5'd0};

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{CMD_TICK,   3'd5,           10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd0,           10'd0,    1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_TICK,   3'd2,           10'd0,    1'b0}, 1'b1, '{8'd13, 8'd157, -5'sd9, 1'b0}},
    '{'{CMD_SAMPLE, 3'd0,           10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd6,           10'd500,  1'b1}, 1'b0, NO_DRIVE},
    '{'{CMD_TICK,   3'd7,           10'd512,  1'b0}, 1'b1, '{8'd157, 8'd13, 5'sd9, 1'b0}},
    '{'{CMD_TICK,   3'd0,           10'd0,    1'b1}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, THRESH_CHANNEL, 10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd0,           10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd1,           10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd2,           10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd3,           10'd1023, 1'b1}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd4,           10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd5,           10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd6,           10'd1023, 1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_TICK,   3'd0,           10'd0,    1'b0}, 1'b1, '{8'd85, 8'd85, 5'sd0, 1'b0}},
    '{'{CMD_TICK,   3'd3,           10'd341,  1'b0}, 1'b1, '{8'd0, 8'd0, 5'sd0, 1'b1}},
    '{'{CMD_TICK,   3'd0,           10'd0,    1'b1}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, THRESH_CHANNEL, 10'd0,    1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd6,           10'd1,    1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_TICK,   3'd0,           10'd0,    1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_SAMPLE, 3'd0,           10'd1,    1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_TICK,   3'd1,           10'd682,  1'b0}, 1'b0, NO_DRIVE},
    '{'{CMD_TICK,   3'd6,           10'd0,    1'b0}, 1'b0, NO_DRIVE}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_cmd = CMD_SAMPLE;
  logic [2:0]            in_channel = '0;
  logic [SB-1:0]         in_sample = '0;
  logic                  in_obstacle = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_left_drive;
  logic [7:0]            out_right_drive;
  logic signed [4:0]     out_position_error;
  logic                  out_all_dark_stop;

  logic [6:0]    line_bits;
  logic [SB-1:0] thresh;
  logic [2:0]    last_count;
  logic [7:0]    base_duty;
  logic [4:0]    gain;

  drive_t      pending_drives [$];
  int          burst_left;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run = 0;
  int          items_sent = 0;
  int          drives_seen = 0;
  int          stops_seen = 0;
  int          sat_seen = 0;
  int          errors = 0;

  line_sensor_p_steering dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_channel         (in_channel),
    .in_sample          (in_sample),
    .in_obstacle        (in_obstacle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_drive     (out_left_drive),
    .out_right_drive    (out_right_drive),
    .out_position_error (out_position_error),
    .out_all_dark_stop  (out_all_dark_stop)
  );

  always #5 clk = ~clk;

  function automatic bit steer_predict(input steer_item_t it, output drive_t d);
    int i;
    int count;
    int sum;
    int err;
    int corr;
    int l;
    int r;
    bit produced;
    d = NO_DRIVE;
    produced = 1'b0;
    if (it.cmd == CMD_SAMPLE) begin
      if (it.channel == THRESH_CHANNEL) begin
        thresh = it.sample;
      end else begin
        line_bits[it.channel] = (it.sample <= thresh);
      end
      return 1'b0;
    end
    count = 0;
    sum = 0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      if (line_bits[i]) begin
        count++;
        sum += LINE_WEIGHT[i];
      end
    end
    if (count != 0 && !it.obstacle) begin
      err = sum / count;
      corr = int'(gain) * err;
      if (count == SENSOR_COUNT && last_count == ALL_COUNT) begin
        d.stop = 1'b1;
      end else begin
        l = int'(base_duty) + corr;
        r = int'(base_duty) - corr;
        d.left = (l < 0) ? 8'd0 : (l > 255) ? 8'd255 : l[7:0];
        d.right = (r < 0) ? 8'd0 : (r > 255) ? 8'd255 : r[7:0];
      end
      d.err = err[4:0];
      produced = 1'b1;
    end
    last_count = count[2:0];
    return produced;
  endfunction

  function automatic steer_item_t random_item();
    steer_item_t it;
    int pick;
    int v;
    it.cmd = CMD_SAMPLE;
    it.channel = 3'($urandom_range(0, 7));
    it.sample = SB'($urandom_range(0, SMP_MAX));
    it.obstacle = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.channel = THRESH_CHANNEL;
      case ($urandom_range(0, 3))
        0: it.sample = SB'(SMP_MAX);
        1: it.sample = '0;
        default: it.sample = SB'($urandom_range(0, SMP_MAX));
      endcase
    end else if (pick < 60) begin
      it.channel = 3'($urandom_range(0, SENSOR_COUNT - 1));
      if ($urandom_range(0, 1)) begin
        v = int'(thresh) + int'($urandom_range(0, 16)) - 8;
        it.sample = (v < 0) ? '0 : (v > SMP_MAX) ? SB'(SMP_MAX) : SB'(v);
      end
    end else begin
      it.cmd = CMD_TICK;
      it.obstacle = ($urandom_range(0, 9) == 0);
    end
    return it;
  endfunction

  task automatic issue(input steer_item_t it, input bit typed, input drive_t want);
    drive_t d;
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_cmd = it.cmd;
    in_channel = it.channel;
    in_sample = it.sample;
    in_obstacle = it.obstacle;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (steer_predict(it, d)) begin
      pending_drives.push_back(typed ? want : d);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk) in_valid = 1'b0;
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_BASE_SPEED) begin
      base_duty = val;
    end else begin
      gain = val[4:0];
    end
  endtask

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run = $urandom_range(8, 60);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE: out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default: out_stall = ~out_stall;
    endcase
  end

  always @(posedge clk) begin : check_drive
    drive_t head;
    if (rst_n && out_valid && !out_stall) begin
      drives_seen++;
      if (out_all_dark_stop) stops_seen++;
      else if (out_left_drive inside {8'd0, 8'd255} || out_right_drive inside {8'd0, 8'd255})
        sat_seen++;
      if (pending_drives.size() == 0) begin
        errors++;
        $display("%0t: unexpected result left %0d right %0d err %0d stop %0b", $time,
                 out_left_drive, out_right_drive, out_position_error, out_all_dark_stop);
      end else begin
        head = pending_drives.pop_front();
        if (out_left_drive !== head.left) begin
          errors++;
          $display("%0t: left_drive expected %0d actual %0d", $time, head.left, out_left_drive);
        end
        if (out_right_drive !== head.right) begin
          errors++;
          $display("%0t: right_drive expected %0d actual %0d", $time, head.right,
                   out_right_drive);
        end
        if (out_position_error !== head.err) begin
          errors++;
          $display("%0t: position_error expected %0d actual %0d", $time, head.err,
                   out_position_error);
        end
        if (out_all_dark_stop !== head.stop) begin
          errors++;
          $display("%0t: all_dark_stop expected %0b actual %0b", $time, head.stop,
                   out_all_dark_stop);
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("** line_sensor_p_steering: FAILED **");
    $finish;
  end

  initial begin
    int i;
    int ph;
    logic [7:0] b;
    logic [4:0] g;
    line_bits = '0;
    thresh = SB'(THRESH_RESET);
    last_count = '0;
    base_duty = BASE_RESET;
    gain = GAIN_RESET;
    burst_left = 1;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    for (i = 0; i < DIR_ROWS; i++) begin
      issue(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    end
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      quiesce();
      if (ph < 4) begin
        b = EDGE_BASE[ph];
        g = EDGE_GAIN[ph];
      end else begin
        b = 8'($urandom_range(0, 255));
        g = 5'($urandom_range(0, 31));
      end
      write_reg(REG_BASE_SPEED, b);
      write_reg(REG_STEER_GAIN, CFG_DATA_W'(g));
      repeat (PHASE_ITEMS) issue(random_item(), 1'b0, NO_DRIVE);
    end
    quiesce();
    repeat (SETTLE_TAIL) @(posedge clk);
    $display("Transferred %0d items over %0d base/gain settings plus reset values.",
             items_sent, RAND_PHASES);
    $display("Checked %0d drive results: %0d all-dark stops, %0d at a saturation limit.",
             drives_seen, stops_seen, sat_seen);
    if (errors == 0) begin
      $display("** line_sensor_p_steering: PASSED **");
    end else begin
      $display("** line_sensor_p_steering: FAILED **");
    end
    $finish;
  end

endmodule
